[hdl/mch_pkg.sv]
// ---------------------------------------------------------------------------
// mch_pkg: shared types and constants of the convex hull block
// Point format, cell control word and sizes used by the cell row and the
// scan sequencer.
// ---------------------------------------------------------------------------
package mch_pkg;

  localparam int MaxPoints  = 64;
  localparam int CoordBits  = 16;
  localparam int IdxBits    = $clog2(MaxPoints);
  localparam int CntBits    = $clog2(MaxPoints + 1);
  localparam int StackDepth = 2 * MaxPoints;
  localparam int StackBits  = $clog2(StackDepth);
  localparam int TopBits    = $clog2(StackDepth + 1);
  localparam int DiffBits   = CoordBits + 1;
  localparam int ProdBits   = 2 * DiffBits;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
  } point_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

[hdl/mch_cell.sv]
// ---------------------------------------------------------------------------
// mch_cell: one slot of the sorted point row
// Holds one point; on insert keeps, takes the new point or takes the left
// neighbor's point so the row stays sorted by x then y; on shift takes the
// right neighbor's point.
// ---------------------------------------------------------------------------
module mch_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mch_pkg::cell_ctrl_t ctrl_i,
  input  mch_pkg::point_t     new_pt_i,
  input  logic                left_valid_i,
  input  logic                left_gt_i,
  input  mch_pkg::point_t     left_pt_i,
  input  logic                right_valid_i,
  input  mch_pkg::point_t     right_pt_i,
  output logic                valid_o,
  output logic                gt_o,
  output mch_pkg::point_t     pt_o
);

  logic            valid_q, valid_d;
  mch_pkg::point_t pt_q, pt_d;

  assign gt_o = valid_q && ((pt_q.x > new_pt_i.x) ||
                            ((pt_q.x == new_pt_i.x) && (pt_q.y > new_pt_i.y)));

  always_comb begin
    valid_d = valid_q;
    pt_d    = pt_q;
    if (ctrl_i.shift) begin
      valid_d = right_valid_i;
      pt_d    = right_pt_i;
    end else if (ctrl_i.insert) begin
      if (left_gt_i) begin
        valid_d = 1'b1;
        pt_d    = left_pt_i;
      end else if (gt_o || (!valid_q && left_valid_i)) begin
        valid_d = 1'b1;
        pt_d    = new_pt_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q <= pt_d;
  end

  assign valid_o = valid_q;
  assign pt_o    = pt_q;

endmodule

[hdl/mch_scan.sv]
// ---------------------------------------------------------------------------
// mch_scan: hull sequencer
// Counts and inserts sites, drains the sorted row into the point memory,
// runs the upper and lower chain scans on the index stack and emits the
// hull vertices.
// ---------------------------------------------------------------------------
module mch_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          is_final_i,
  input  mch_pkg::point_t               head_pt_i,
  output mch_pkg::cell_ctrl_t           ctrl_o,
  output logic                          busy_o,
  output logic                          res_valid_o,
  output logic signed [mch_pkg::CoordBits-1:0] hx_o,
  output logic signed [mch_pkg::CoordBits-1:0] hy_o,
  output logic [mch_pkg::IdxBits-1:0]   vertex_index_o,
  output logic                          end_of_hull_o,
  output logic                          overflow_o
);

  typedef enum logic [13:0] {
    S_LOAD  = 14'b00000000000001,
    S_DRAIN = 14'b00000000000010,
    S_SC_RD = 14'b00000000000100,
    S_SC_C  = 14'b00000000001000,
    S_MUL   = 14'b00000000010000,
    S_CMP   = 14'b00000000100000,
    S_PUSH  = 14'b00000001000000,
    S_POP_S = 14'b00000010000000,
    S_POP_W = 14'b00000100000000,
    S_POP_A = 14'b00001000000000,
    S_E_RD  = 14'b00010000000000,
    S_E_IDX = 14'b00100000000000,
    S_E_PT  = 14'b01000000000000,
    S_E_END = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [mch_pkg::CntBits-1:0]   cnt_q, cnt_d;
  logic                          ovf_q, ovf_d;
  logic [mch_pkg::IdxBits-1:0]   k_q, k_d;
  logic [mch_pkg::IdxBits-1:0]   i_q, i_d;
  logic                          lower_q, lower_d;
  logic                          direct_q, direct_d;
  logic [mch_pkg::TopBits-1:0]   top_q, top_d;
  logic [mch_pkg::TopBits-1:0]   floor_q, floor_d;
  logic [mch_pkg::TopBits-1:0]   j_q, j_d;
  logic [mch_pkg::MaxPoints-1:0] seen_q, seen_d;
  logic                          pend_v_q, pend_v_d;

  mch_pkg::point_t a_q, a_d, b_q, b_d, c_q, c_d, pend_pt_q, pend_pt_d;
  logic [mch_pkg::IdxBits-1:0] pend_idx_q, pend_idx_d, idx_q, idx_d;
  logic signed [mch_pkg::ProdBits-1:0] p1_q, p2_q;

  // memories
  mch_pkg::point_t             pmem [mch_pkg::MaxPoints];
  logic [mch_pkg::IdxBits-1:0] smem [mch_pkg::StackDepth];
  mch_pkg::point_t             prd_q;
  logic [mch_pkg::IdxBits-1:0] srd_q;
  logic [mch_pkg::IdxBits-1:0] prd_addr;
  logic [mch_pkg::StackBits-1:0] srd_addr;
  logic                        pwr_en, swr_en;

  logic [mch_pkg::IdxBits-1:0] last_idx;
  logic [mch_pkg::IdxBits-1:0] e_idx;
  logic [mch_pkg::TopBits-1:0] e_top;
  logic [mch_pkg::TopBits-1:0] top_m1;
  logic signed [mch_pkg::DiffBits-1:0] dx1, dy1, dx2, dy2;

  logic                        res_v_q, res_v_d, res_end_d;
  mch_pkg::point_t             res_pt_d;
  logic [mch_pkg::IdxBits-1:0] res_idx_d;
  logic                        res_end_q, res_ovf_q;
  mch_pkg::point_t             res_pt_q;
  logic [mch_pkg::IdxBits-1:0] res_idx_q;

  assign last_idx = mch_pkg::IdxBits'(cnt_q - mch_pkg::CntBits'(1));
  assign e_idx    = direct_q ? j_q[mch_pkg::IdxBits-1:0] : srd_q;
  assign e_top    = direct_q ? mch_pkg::TopBits'(cnt_q) : top_q;
  assign top_m1   = top_q - mch_pkg::TopBits'(1);

  assign dx1 = mch_pkg::DiffBits'(b_q.x) - mch_pkg::DiffBits'(a_q.x);
  assign dy1 = mch_pkg::DiffBits'(b_q.y) - mch_pkg::DiffBits'(a_q.y);
  assign dx2 = mch_pkg::DiffBits'(c_q.x) - mch_pkg::DiffBits'(a_q.x);
  assign dy2 = mch_pkg::DiffBits'(c_q.y) - mch_pkg::DiffBits'(a_q.y);

  always_comb begin
    prd_addr = '0;
    srd_addr = '0;
    unique case (state_q)
      S_SC_RD: prd_addr = i_q;
      S_POP_W: prd_addr = srd_q;
      S_E_IDX: prd_addr = e_idx;
      default: prd_addr = '0;
    endcase
    unique case (state_q)
      S_POP_S: srd_addr = mch_pkg::StackBits'(top_q - mch_pkg::TopBits'(3));
      S_E_RD:  srd_addr = j_q[mch_pkg::StackBits-1:0];
      default: srd_addr = '0;
    endcase
  end

  assign pwr_en = (state_q == S_DRAIN);
  assign swr_en = (state_q == S_PUSH);

  always_ff @(posedge clk_i) begin
    if (pwr_en) begin
      pmem[k_q] <= head_pt_i;
    end
    prd_q <= pmem[prd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (swr_en) begin
      smem[top_q[mch_pkg::StackBits-1:0]] <= i_q;
    end
    srd_q <= smem[srd_addr];
  end

  always_ff @(posedge clk_i) begin
    p1_q <= dx1 * dy2;
    p2_q <= dy1 * dx2;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    k_d        = k_q;
    i_d        = i_q;
    lower_d    = lower_q;
    direct_d   = direct_q;
    top_d      = top_q;
    floor_d    = floor_q;
    j_d        = j_q;
    seen_d     = seen_q;
    pend_v_d   = pend_v_q;
    pend_pt_d  = pend_pt_q;
    pend_idx_d = pend_idx_q;
    idx_d      = idx_q;
    a_d        = a_q;
    b_d        = b_q;
    c_d        = c_q;
    res_v_d    = 1'b0;
    res_end_d  = 1'b0;
    res_pt_d   = pend_pt_q;
    res_idx_d  = pend_idx_q;
    ctrl_o     = '0;

    unique case (state_q)
      S_LOAD: begin
        if (accept_i) begin
          if (cnt_q < mch_pkg::CntBits'(mch_pkg::MaxPoints)) begin
            ctrl_o.insert = 1'b1;
            cnt_d         = cnt_q + mch_pkg::CntBits'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (is_final_i) begin
            k_d     = '0;
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        // move the row head into memory and advance the row
        ctrl_o.shift = 1'b1;
        k_d          = k_q + mch_pkg::IdxBits'(1);
        if (k_q == last_idx) begin
          seen_d   = '0;
          pend_v_d = 1'b0;
          j_d      = '0;
          top_d    = '0;
          i_d      = '0;
          lower_d  = 1'b0;
          floor_d  = mch_pkg::TopBits'(2);
          if (cnt_q < mch_pkg::CntBits'(3)) begin
            direct_d = 1'b1;
            state_d  = S_E_RD;
          end else begin
            direct_d = 1'b0;
            state_d  = S_SC_RD;
          end
        end
      end
      S_SC_RD: state_d = S_SC_C;
      S_SC_C: begin
        c_d     = prd_q;
        state_d = (top_q >= floor_q) ? S_MUL : S_PUSH;
      end
      S_MUL: state_d = S_CMP;
      S_CMP: state_d = (p1_q > p2_q) ? S_POP_S : S_PUSH;
      S_POP_S: begin
        // drop the top; the old second entry becomes the top
        top_d   = top_m1;
        b_d     = a_q;
        state_d = (top_m1 >= floor_q) ? S_POP_W : S_PUSH;
      end
      S_POP_W: state_d = S_POP_A;
      S_POP_A: begin
        a_d     = prd_q;
        state_d = S_MUL;
      end
      S_PUSH: begin
        top_d   = top_q + mch_pkg::TopBits'(1);
        a_d     = b_q;
        b_d     = c_q;
        state_d = S_SC_RD;
        if (!lower_q) begin
          if (i_q == last_idx) begin
            lower_d = 1'b1;
            floor_d = top_q + mch_pkg::TopBits'(2);
            i_d     = last_idx - mch_pkg::IdxBits'(1);
          end else begin
            i_d = i_q + mch_pkg::IdxBits'(1);
          end
        end else if (i_q == '0) begin
          state_d = S_E_RD;
        end else begin
          i_d = i_q - mch_pkg::IdxBits'(1);
        end
      end
      S_E_RD: state_d = (j_q == e_top) ? S_E_END : S_E_IDX;
      S_E_IDX: begin
        j_d = j_q + mch_pkg::TopBits'(1);
        if (seen_q[e_idx]) begin
          state_d = S_E_RD;
        end else begin
          seen_d[e_idx] = 1'b1;
          idx_d         = e_idx;
          state_d       = S_E_PT;
        end
      end
      S_E_PT: begin
        // hold one vertex back so the last one can be flagged
        res_v_d    = pend_v_q;
        pend_v_d   = 1'b1;
        pend_pt_d  = prd_q;
        pend_idx_d = idx_q;
        state_d    = S_E_RD;
      end
      S_E_END: begin
        res_v_d   = pend_v_q;
        res_end_d = 1'b1;
        cnt_d     = '0;
        ovf_d     = 1'b0;
        pend_v_d  = 1'b0;
        state_d   = S_LOAD;
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      k_q      <= '0;
      i_q      <= '0;
      lower_q  <= 1'b0;
      direct_q <= 1'b0;
      top_q    <= '0;
      floor_q  <= '0;
      j_q      <= '0;
      seen_q   <= '0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      k_q      <= k_d;
      i_q      <= i_d;
      lower_q  <= lower_d;
      direct_q <= direct_d;
      top_q    <= top_d;
      floor_q  <= floor_d;
      j_q      <= j_d;
      seen_q   <= seen_d;
      pend_v_q <= pend_v_d;
      res_v_q  <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    c_q        <= c_d;
    idx_q      <= idx_d;
    pend_pt_q  <= pend_pt_d;
    pend_idx_q <= pend_idx_d;
    res_pt_q   <= res_pt_d;
    res_idx_q  <= res_idx_d;
    res_end_q  <= res_end_d;
    res_ovf_q  <= ovf_q;
  end

  assign busy_o         = (state_q != S_LOAD);
  assign res_valid_o    = res_v_q;
  assign hx_o           = res_pt_q.x;
  assign hy_o           = res_pt_q.y;
  assign vertex_index_o = res_idx_q;
  assign end_of_hull_o  = res_end_q;
  assign overflow_o     = res_ovf_q;

endmodule

[hdl/monotone_chain_convex_hull.sv]
// ---------------------------------------------------------------------------
// monotone_chain_convex_hull: convex hull of up to 64 signed points
// Sites load one per cycle into a sorted row of cells; the final site starts
// the hull scans and the vertices come out clockwise from the leftmost point.
// ---------------------------------------------------------------------------
// Sites are taken one per cycle while busy is low; a site beyond 64 is
// dropped and flags overflow_o on every vertex of that set. The site with
// is_final_i high starts the hull and raises busy. Work after that drains the
// sorted row into the point memory, runs the upper and lower chain scans with
// their pops and then emits the stack entries, all paced by the single read
// port of the point memory. Each vertex word is shown for one cycle with
// res_valid_o and must be taken then; the last one of a set carries
// end_of_hull_o. busy falls in the cycle of the last vertex word.
module monotone_chain_convex_hull (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [mch_pkg::CoordBits-1:0] px_i,
  input  logic signed [mch_pkg::CoordBits-1:0] py_i,
  input  logic                                 is_final_i,
  output logic                                 res_valid_o,
  output logic signed [mch_pkg::CoordBits-1:0] hx_o,
  output logic signed [mch_pkg::CoordBits-1:0] hy_o,
  output logic [mch_pkg::IdxBits-1:0]          vertex_index_o,
  output logic                                 end_of_hull_o,
  output logic                                 overflow_o
);

  mch_pkg::cell_ctrl_t ctrl;
  mch_pkg::point_t     new_pt;
  logic                accept;

  logic            valid [mch_pkg::MaxPoints];
  logic            gt    [mch_pkg::MaxPoints];
  mch_pkg::point_t pt    [mch_pkg::MaxPoints];

  assign accept   = start && !busy;
  assign new_pt.x = px_i;
  assign new_pt.y = py_i;

  for (genvar g = 0; g < mch_pkg::MaxPoints; g++) begin : g_cell
    logic            l_valid, l_gt, r_valid;
    mch_pkg::point_t l_pt, r_pt;
    if (g == 0) begin : g_first
      assign l_valid = 1'b1;
      assign l_gt    = 1'b0;
      assign l_pt    = new_pt;
    end else begin : g_mid
      assign l_valid = valid[g-1];
      assign l_gt    = gt[g-1];
      assign l_pt    = pt[g-1];
    end
    if (g == mch_pkg::MaxPoints - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_pt    = new_pt;
    end else begin : g_inner
      assign r_valid = valid[g+1];
      assign r_pt    = pt[g+1];
    end
    mch_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_pt_i      (new_pt),
      .left_valid_i  (l_valid),
      .left_gt_i     (l_gt),
      .left_pt_i     (l_pt),
      .right_valid_i (r_valid),
      .right_pt_i    (r_pt),
      .valid_o       (valid[g]),
      .gt_o          (gt[g]),
      .pt_o          (pt[g])
    );
  end

  mch_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .is_final_i     (is_final_i),
    .head_pt_i      (pt[0]),
    .ctrl_o         (ctrl),
    .busy_o         (busy),
    .res_valid_o    (res_valid_o),
    .hx_o           (hx_o),
    .hy_o           (hy_o),
    .vertex_index_o (vertex_index_o),
    .end_of_hull_o  (end_of_hull_o),
    .overflow_o     (overflow_o)
  );

`ifndef SYNTHESIS
  a_final_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_final_i) |=> busy)
    else $error("final site did not start the hull");

  a_end_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && end_of_hull_o) |=> !res_valid_o)
    else $error("word after end of hull");

  a_no_word_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> !res_valid_o)
    else $error("vertex word while a new set starts");

  a_idle_no_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !$past(busy)) |-> !res_valid_o)
    else $error("vertex word while loading");
`endif

endmodule

[tb/sv/monotone_chain_convex_hull_tb.sv]
// ---------------------------------------------------------------------------
// monotone_chain_convex_hull_tb: self-checking bench for the hull block
// Feeds point sets through start/busy with random bursts and gaps, predicts
// the clockwise hull of every set and checks each vertex word as it appears.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module monotone_chain_convex_hull_tb;

  localparam int CycleLimit = 400000;

  typedef struct {
    logic [mch_pkg::CoordBits-1:0] x;
    logic [mch_pkg::CoordBits-1:0] y;
    logic                          fin;
  } site_t;

  typedef struct {
    logic [mch_pkg::CoordBits-1:0] x;
    logic [mch_pkg::CoordBits-1:0] y;
    logic [mch_pkg::IdxBits-1:0]   idx;
    logic                          last;
    logic                          ovf;
  } vertex_t;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 start;
  logic                                 busy;
  logic signed [mch_pkg::CoordBits-1:0] px_i;
  logic signed [mch_pkg::CoordBits-1:0] py_i;
  logic                                 is_final_i;
  logic                                 res_valid_o;
  logic signed [mch_pkg::CoordBits-1:0] hx_o;
  logic signed [mch_pkg::CoordBits-1:0] hy_o;
  logic [mch_pkg::IdxBits-1:0]          vertex_index_o;
  logic                                 end_of_hull_o;
  logic                                 overflow_o;

  site_t   site_q[$];
  vertex_t hull_q[$];
  int      items_queued;
  int      burst_left;
  int      gap_left;
  int      cycles;
  bit      failed;

  // predictor state
  longint sx[mch_pkg::MaxPoints];
  longint sy[mch_pkg::MaxPoints];
  int     site_cnt;
  bit     ovf_seen;
  int     stk[mch_pkg::StackDepth];
  int     top;

  monotone_chain_convex_hull dut (
    .clk_i, .rst_ni, .start, .busy, .px_i, .py_i, .is_final_i,
    .res_valid_o, .hx_o, .hy_o, .vertex_index_o, .end_of_hull_o, .overflow_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic bit left_turn(int a, int b, int c);
    return (sx[b] - sx[a]) * (sy[c] - sy[a]) > (sy[b] - sy[a]) * (sx[c] - sx[a]);
  endfunction

  function automatic void push_scan(int i, int floor_top);
    while (top >= floor_top && left_turn(stk[top-2], stk[top-1], i)) top--;
    if (top < mch_pkg::StackDepth) begin
      stk[top] = i;
      top++;
    end
  endfunction

  function automatic void emit_vertex(int idx);
    vertex_t v;
    v.x = sx[idx][mch_pkg::CoordBits-1:0];
    v.y = sy[idx][mch_pkg::CoordBits-1:0];
    v.idx = idx[mch_pkg::IdxBits-1:0];
    v.last = 1'b0;
    v.ovf = ovf_seen;
    hull_q.push_back(v);
  endfunction

  // store one accepted site; a final site closes the set and predicts its hull
  function automatic void take_site(site_t s);
    longint kx, ky;
    int j, upper, first;
    bit seen[mch_pkg::MaxPoints];
    if (site_cnt < mch_pkg::MaxPoints) begin
      sx[site_cnt] = longint'($signed(s.x));
      sy[site_cnt] = longint'($signed(s.y));
      site_cnt++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (!s.fin) return;
    for (int i = 1; i < site_cnt; i++) begin
      kx = sx[i];
      ky = sy[i];
      j = i;
      while (j > 0 && (sx[j-1] > kx || (sx[j-1] == kx && sy[j-1] > ky))) begin
        sx[j] = sx[j-1];
        sy[j] = sy[j-1];
        j--;
      end
      sx[j] = kx;
      sy[j] = ky;
    end
    first = hull_q.size();
    top = 0;
    if (site_cnt < 3) begin
      for (int i = 0; i < site_cnt; i++) emit_vertex(i);
    end else begin
      for (int i = 0; i < site_cnt; i++) push_scan(i, 2);
      upper = top;
      for (int i = site_cnt - 2; i >= 0; i--) push_scan(i, upper + 1);
      foreach (seen[i]) seen[i] = 1'b0;
      for (int i = 0; i < top; i++) begin
        if (!seen[stk[i]]) begin
          seen[stk[i]] = 1'b1;
          emit_vertex(stk[i]);
        end
      end
    end
    if (hull_q.size() > first) hull_q[hull_q.size()-1].last = 1'b1;
    site_cnt = 0;
    top = 0;
    ovf_seen = 1'b0;
  endfunction

  // driver: hold a word until accepted, then advance or idle
  always @(posedge clk_i or negedge rst_ni) begin
    site_t s;
    if (!rst_ni) begin
      start      <= 1'b0;
      px_i       <= '0;
      py_i       <= '0;
      is_final_i <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (start && !busy) take_site('{px_i, py_i, is_final_i});
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (site_q.size() > 0) begin
          s = site_q.pop_front();
          px_i       <= s.x;
          py_i       <= s.y;
          is_final_i <= s.fin;
          start      <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed vertex word must match the oldest prediction
  always @(posedge clk_i) begin
    vertex_t e;
    if (rst_ni && res_valid_o) begin
      if (hull_q.size() == 0) begin
        $display("%0t: unexpected vertex x=%0d y=%0d idx=%0d", $time, hx_o, hy_o,
                 vertex_index_o);
        failed = 1'b1;
      end else begin
        e = hull_q.pop_front();
        if (hx_o !== e.x) begin
          $display("%0t: hx expected %0d actual %0d", $time, $signed(e.x), hx_o);
          failed = 1'b1;
        end
        if (hy_o !== e.y) begin
          $display("%0t: hy expected %0d actual %0d", $time, $signed(e.y), hy_o);
          failed = 1'b1;
        end
        if (vertex_index_o !== e.idx) begin
          $display("%0t: vertex_index expected %0d actual %0d", $time, e.idx,
                   vertex_index_o);
          failed = 1'b1;
        end
        if (end_of_hull_o !== e.last) begin
          $display("%0t: end_of_hull expected %0b actual %0b", $time, e.last,
                   end_of_hull_o);
          failed = 1'b1;
        end
        if (overflow_o !== e.ovf) begin
          $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, overflow_o);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_site(int x, int y, bit fin);
    site_q.push_back('{x[mch_pkg::CoordBits-1:0], y[mch_pkg::CoordBits-1:0], fin});
    items_queued++;
  endtask

  // narrow sets make collinear and repeated sites common
  task automatic queue_random_set(int n, bit narrow);
    for (int i = 0; i < n; i++) begin
      if (narrow) queue_site($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3, i == n - 1);
      else queue_site($urandom, $urandom, i == n - 1);
    end
  endtask

  initial begin
    int n;
    failed = 1'b0;
    items_queued = 0;
    cycles = 0;
    site_cnt = 0;
    ovf_seen = 1'b0;
    top = 0;
    // single site at the extremes
    queue_site(-32768, 32767, 1);
    // two sites
    queue_site(32767, -32768, 0);
    queue_site(-1, 0, 1);
    // all collinear
    queue_site(3, 3, 0);
    queue_site(0, 0, 0);
    queue_site(2, 2, 0);
    queue_site(1, 1, 1);
    // repeated site
    queue_site(5, 5, 0);
    queue_site(5, 5, 0);
    queue_site(5, 5, 1);
    // extreme corners around an interior point
    queue_site(0, 0, 0);
    queue_site(32767, 32767, 0);
    queue_site(-32768, -32768, 0);
    queue_site(32767, -32768, 0);
    queue_site(-32768, 32767, 1);
    // full store, then overflow with a dropped final site
    queue_random_set(mch_pkg::MaxPoints, 1'b0);
    queue_random_set(mch_pkg::MaxPoints + 3, 1'b0);
    while (items_queued < 260) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      queue_random_set(n, $urandom_range(0, 2) == 0);
    end
    wait (rst_ni);
    wait (site_q.size() == 0 && !start && hull_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (!failed && hull_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
